// ===== sv/wsc_pkg.sv =====
// shared types and constants for the wheel speed and cadence calculator
`timescale 1ns / 1ps

package wsc_pkg;

    localparam int COEF_W     = 16;
    localparam int CAP_W      = 8;
    localparam int RES_W      = 8;
    localparam int BIT_IDX_W  = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;
    localparam int Q_CNT_W = 2;

    localparam logic [COEF_W-1:0] SPEED_COEF_RST   = 16'd7630;
    localparam logic [COEF_W-1:0] CADENCE_COEF_RST = 16'd61440;
    localparam logic [CAP_W-1:0]  SPEED_CAP_RST    = 8'd150;
    localparam logic [CAP_W-1:0]  CADENCE_CAP_RST  = 8'd200;

    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_COEF   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CADENCE_COEF = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_CAP    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CADENCE_CAP  = 2'd3;

    localparam logic [BIT_IDX_W-1:0] DIV_TOP_BIT = 3'd7;

    typedef enum logic {
        OP_UPDATE = 1'b0,
        OP_CLEAR  = 1'b1
    } t_opcode;

    typedef struct packed {
        logic [COEF_W-1:0] speed_coef;
        logic [COEF_W-1:0] cadence_coef;
        logic [CAP_W-1:0]  speed_cap;
        logic [CAP_W-1:0]  cadence_cap;
    } t_cfg;

    typedef struct packed {
        logic wheel_calc;
        logic crank_calc;
    } t_job_flags;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_MUL,
        BK_RANGE,
        BK_DIV,
        BK_OUT
    } t_back_state;

endpackage

// ===== sv/wsc_front.sv =====
// front end: accepts items, keeps channel history and builds division jobs
`timescale 1ns / 1ps

module wsc_front #(
    parameter int COUNT_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic                  i_opcode,
    input  logic [COUNT_BITS-1:0] i_wheel_revs,
    input  logic [COUNT_BITS-1:0] i_wheel_time,
    input  logic [COUNT_BITS-1:0] i_crank_revs,
    input  logic [COUNT_BITS-1:0] i_crank_time,
    input  logic                  i_full,
    output logic                  o_push,
    output wsc_pkg::t_job_flags   o_flags,
    output logic [COUNT_BITS-1:0] o_wheel_dr,
    output logic [COUNT_BITS-1:0] o_wheel_dt,
    output logic [COUNT_BITS-1:0] o_crank_dr,
    output logic [COUNT_BITS-1:0] o_crank_dt
);

    logic                  r_wheel_seen, n_wheel_seen;
    logic [COUNT_BITS-1:0] r_wheel_revs, n_wheel_revs;
    logic [COUNT_BITS-1:0] r_wheel_time, n_wheel_time;
    logic                  r_crank_seen, n_crank_seen;
    logic [COUNT_BITS-1:0] r_crank_revs, n_crank_revs;
    logic [COUNT_BITS-1:0] r_crank_time, n_crank_time;
    logic                  accept;

    assign o_ready    = !i_full;
    assign accept     = i_valid && !i_full;
    assign o_wheel_dr = i_wheel_revs - r_wheel_revs;
    assign o_wheel_dt = i_wheel_time - r_wheel_time;
    assign o_crank_dr = i_crank_revs - r_crank_revs;
    assign o_crank_dt = i_crank_time - r_crank_time;

    always_comb begin
        n_wheel_seen = r_wheel_seen;
        n_wheel_revs = r_wheel_revs;
        n_wheel_time = r_wheel_time;
        n_crank_seen = r_crank_seen;
        n_crank_revs = r_crank_revs;
        n_crank_time = r_crank_time;
        o_push       = 1'b0;
        o_flags      = '0;
        if (accept) begin
            if (i_opcode == wsc_pkg::OP_CLEAR) begin
                n_wheel_seen = 1'b0;
                n_wheel_revs = '0;
                n_wheel_time = '0;
                n_crank_seen = 1'b0;
                n_crank_revs = '0;
                n_crank_time = '0;
            end else begin
                o_push = 1'b1;
                // wheel channel
                if (!r_wheel_seen) begin
                    n_wheel_seen = 1'b1;
                    n_wheel_revs = i_wheel_revs;
                    n_wheel_time = i_wheel_time;
                end else if (i_wheel_revs != r_wheel_revs) begin
                    n_wheel_revs       = i_wheel_revs;
                    n_wheel_time       = i_wheel_time;
                    o_flags.wheel_calc = (o_wheel_dt != '0);
                end
                // crank channel
                if (!r_crank_seen) begin
                    n_crank_seen = 1'b1;
                    n_crank_revs = i_crank_revs;
                    n_crank_time = i_crank_time;
                end else if (i_crank_revs != r_crank_revs) begin
                    n_crank_revs       = i_crank_revs;
                    n_crank_time       = i_crank_time;
                    o_flags.crank_calc = (o_crank_dt != '0);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wheel_seen <= 1'b0;
            r_wheel_revs <= '0;
            r_wheel_time <= '0;
            r_crank_seen <= 1'b0;
            r_crank_revs <= '0;
            r_crank_time <= '0;
        end else begin
            r_wheel_seen <= n_wheel_seen;
            r_wheel_revs <= n_wheel_revs;
            r_wheel_time <= n_wheel_time;
            r_crank_seen <= n_crank_seen;
            r_crank_revs <= n_crank_revs;
            r_crank_time <= n_crank_time;
        end
    end

endmodule

// ===== sv/wsc_fifo.sv =====
// two-entry job queue between front and back end
`timescale 1ns / 1ps

module wsc_fifo #(
    parameter int DATA_W = 66
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_empty,
    output logic [DATA_W-1:0] o_data
);

    logic [DATA_W-1:0]           r_mem [wsc_pkg::Q_DEPTH];
    logic [wsc_pkg::Q_PTR_W-1:0] r_wr_ptr;
    logic [wsc_pkg::Q_PTR_W-1:0] r_rd_ptr;
    logic [wsc_pkg::Q_CNT_W-1:0] r_count;
    logic                        do_push;
    logic                        do_pop;

    assign o_full  = (r_count == wsc_pkg::Q_CNT_W'(wsc_pkg::Q_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== sv/wsc_back.sv =====
// back end: multiply, range check, 8-step restoring divide and cap check
`timescale 1ns / 1ps

module wsc_back #(
    parameter int COUNT_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_empty,
    output logic                              o_pop,
    input  wsc_pkg::t_job_flags               i_flags,
    input  logic [COUNT_BITS-1:0]             i_wheel_dr,
    input  logic [COUNT_BITS-1:0]             i_wheel_dt,
    input  logic [COUNT_BITS-1:0]             i_crank_dr,
    input  logic [COUNT_BITS-1:0]             i_crank_dt,
    input  wsc_pkg::t_cfg                     i_cfg,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [wsc_pkg::RES_W-1:0]         o_speed_kph,
    output logic [wsc_pkg::RES_W-1:0]         o_cadence_rpm
);

    localparam int NUM_W = wsc_pkg::COEF_W + COUNT_BITS;

    wsc_pkg::t_back_state              r_state, n_state;
    wsc_pkg::t_job_flags               r_flags, n_flags;
    logic [COUNT_BITS-1:0]             r_wheel_dr, n_wheel_dr;
    logic [COUNT_BITS-1:0]             r_wheel_dt, n_wheel_dt;
    logic [COUNT_BITS-1:0]             r_crank_dr, n_crank_dr;
    logic [COUNT_BITS-1:0]             r_crank_dt, n_crank_dt;
    logic                              r_ch, n_ch;
    logic [NUM_W-1:0]                  r_num, n_num;
    logic [wsc_pkg::BIT_IDX_W-1:0]     r_bit, n_bit;
    logic [wsc_pkg::RES_W-1:0]         r_quo, n_quo;
    logic [wsc_pkg::RES_W-1:0]         r_spd, n_spd;
    logic [wsc_pkg::RES_W-1:0]         r_cad, n_cad;
    logic                              r_out_valid, n_out_valid;
    logic [wsc_pkg::RES_W-1:0]         r_out_spd, n_out_spd;
    logic [wsc_pkg::RES_W-1:0]         r_out_cad, n_out_cad;

    logic                              cur_calc;
    logic [COUNT_BITS-1:0]             cur_dr;
    logic [COUNT_BITS-1:0]             cur_dt;
    logic [wsc_pkg::COEF_W-1:0]        cur_coef;
    logic [wsc_pkg::CAP_W-1:0]         cur_cap;
    logic [NUM_W-1:0]                  product;
    logic [NUM_W-1:0]                  dt_limit;
    logic [NUM_W-1:0]                  dt_shift;
    logic                              trial_ge;
    logic [wsc_pkg::RES_W-1:0]         quo_next;
    logic                              chan_done;
    logic [wsc_pkg::RES_W-1:0]         chan_val;

    assign cur_calc = r_ch ? r_flags.crank_calc : r_flags.wheel_calc;
    assign cur_dr   = r_ch ? r_crank_dr : r_wheel_dr;
    assign cur_dt   = r_ch ? r_crank_dt : r_wheel_dt;
    assign cur_coef = r_ch ? i_cfg.cadence_coef : i_cfg.speed_coef;
    assign cur_cap  = r_ch ? i_cfg.cadence_cap : i_cfg.speed_cap;
    assign product  = NUM_W'(cur_coef) * NUM_W'(cur_dr);
    assign dt_limit = NUM_W'(cur_dt) << wsc_pkg::RES_W;
    assign dt_shift = NUM_W'(cur_dt) << r_bit;
    assign trial_ge = (r_num >= dt_shift);
    assign quo_next = r_quo | (wsc_pkg::RES_W'(trial_ge) << r_bit);

    assign o_valid       = r_out_valid;
    assign o_speed_kph   = r_out_spd;
    assign o_cadence_rpm = r_out_cad;

    always_comb begin
        n_state     = r_state;
        n_flags     = r_flags;
        n_wheel_dr  = r_wheel_dr;
        n_wheel_dt  = r_wheel_dt;
        n_crank_dr  = r_crank_dr;
        n_crank_dt  = r_crank_dt;
        n_ch        = r_ch;
        n_num       = r_num;
        n_bit       = r_bit;
        n_quo       = r_quo;
        n_spd       = r_spd;
        n_cad       = r_cad;
        n_out_valid = r_out_valid;
        n_out_spd   = r_out_spd;
        n_out_cad   = r_out_cad;
        o_pop       = 1'b0;
        chan_done   = 1'b0;
        chan_val    = '0;

        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            wsc_pkg::BK_IDLE: begin
                if (!i_empty) begin
                    o_pop      = 1'b1;
                    n_flags    = i_flags;
                    n_wheel_dr = i_wheel_dr;
                    n_wheel_dt = i_wheel_dt;
                    n_crank_dr = i_crank_dr;
                    n_crank_dt = i_crank_dt;
                    n_ch       = 1'b0;
                    n_state    = wsc_pkg::BK_MUL;
                end
            end
            wsc_pkg::BK_MUL: begin
                n_num   = product;
                n_state = wsc_pkg::BK_RANGE;
            end
            wsc_pkg::BK_RANGE: begin
                // quotient of 256 or more is always over the cap
                if (!cur_calc || (r_num >= dt_limit)) begin
                    chan_done = 1'b1;
                end else begin
                    n_bit   = wsc_pkg::DIV_TOP_BIT;
                    n_quo   = '0;
                    n_state = wsc_pkg::BK_DIV;
                end
            end
            wsc_pkg::BK_DIV: begin
                if (trial_ge) begin
                    n_num = r_num - dt_shift;
                end
                n_quo = quo_next;
                n_bit = r_bit - 1'b1;
                if (r_bit == '0) begin
                    chan_done = 1'b1;
                    chan_val  = (quo_next > cur_cap) ? '0 : quo_next;
                end
            end
            wsc_pkg::BK_OUT: begin
                if (!r_out_valid || i_ready) begin
                    n_out_valid = 1'b1;
                    n_out_spd   = r_spd;
                    n_out_cad   = r_cad;
                    n_state     = wsc_pkg::BK_IDLE;
                end
            end
            default: begin
                n_state = wsc_pkg::BK_IDLE;
            end
        endcase

        if (chan_done) begin
            if (!r_ch) begin
                n_spd   = chan_val;
                n_ch    = 1'b1;
                n_state = wsc_pkg::BK_MUL;
            end else begin
                n_cad   = chan_val;
                n_state = wsc_pkg::BK_OUT;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= wsc_pkg::BK_IDLE;
            r_out_valid <= 1'b0;
            r_ch        <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_ch        <= n_ch;
        end
    end

    always_ff @(posedge i_clk) begin
        r_flags    <= n_flags;
        r_wheel_dr <= n_wheel_dr;
        r_wheel_dt <= n_wheel_dt;
        r_crank_dr <= n_crank_dr;
        r_crank_dt <= n_crank_dt;
        r_num      <= n_num;
        r_bit      <= n_bit;
        r_quo      <= n_quo;
        r_spd      <= n_spd;
        r_cad      <= n_cad;
        r_out_spd  <= n_out_spd;
        r_out_cad  <= n_out_cad;
    end

endmodule

// ===== sv/wheel_speed_cadence_calc.sv =====
// top level: config registers, front end, job queue and divide back end
// flow: an update passes the front end, the job queue and the back end states multiply and range per channel;
// a divided channel also runs the 8 restoring divide steps; the wheel channel goes before the crank channel
// queue: updates are taken while the back end is busy until the two-entry queue is full; clears push no job
// reset: synchronous active low, clears history, queue, output valid, loads coefficients and caps
`timescale 1ns / 1ps

module wheel_speed_cadence_calc #(
    parameter int COUNT_BITS = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [wsc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [wsc_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic                             i_opcode,
    input  logic [COUNT_BITS-1:0]            i_wheel_revs,
    input  logic [COUNT_BITS-1:0]            i_wheel_time,
    input  logic [COUNT_BITS-1:0]            i_crank_revs,
    input  logic [COUNT_BITS-1:0]            i_crank_time,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [wsc_pkg::RES_W-1:0]        o_speed_kph,
    output logic [wsc_pkg::RES_W-1:0]        o_cadence_rpm
);

    localparam int FLAG_W = $bits(wsc_pkg::t_job_flags);
    localparam int JOB_W  = FLAG_W + 4 * COUNT_BITS;

    wsc_pkg::t_cfg         r_cfg;
    logic                  push;
    logic                  pop;
    logic                  full;
    logic                  empty;
    wsc_pkg::t_job_flags   fr_flags;
    logic [COUNT_BITS-1:0] fr_wheel_dr;
    logic [COUNT_BITS-1:0] fr_wheel_dt;
    logic [COUNT_BITS-1:0] fr_crank_dr;
    logic [COUNT_BITS-1:0] fr_crank_dt;
    logic [JOB_W-1:0]      q_in;
    logic [JOB_W-1:0]      q_out;
    wsc_pkg::t_job_flags   bk_flags;
    logic [COUNT_BITS-1:0] bk_wheel_dr;
    logic [COUNT_BITS-1:0] bk_wheel_dt;
    logic [COUNT_BITS-1:0] bk_crank_dr;
    logic [COUNT_BITS-1:0] bk_crank_dt;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.speed_coef   <= wsc_pkg::SPEED_COEF_RST;
            r_cfg.cadence_coef <= wsc_pkg::CADENCE_COEF_RST;
            r_cfg.speed_cap    <= wsc_pkg::SPEED_CAP_RST;
            r_cfg.cadence_cap  <= wsc_pkg::CADENCE_CAP_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                wsc_pkg::CFG_SPEED_COEF:   r_cfg.speed_coef   <= i_cfg_data;
                wsc_pkg::CFG_CADENCE_COEF: r_cfg.cadence_coef <= i_cfg_data;
                wsc_pkg::CFG_SPEED_CAP:    r_cfg.speed_cap    <= i_cfg_data[wsc_pkg::CAP_W-1:0];
                wsc_pkg::CFG_CADENCE_CAP:  r_cfg.cadence_cap  <= i_cfg_data[wsc_pkg::CAP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    wsc_front #(
        .COUNT_BITS (COUNT_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_opcode     (i_opcode),
        .i_wheel_revs (i_wheel_revs),
        .i_wheel_time (i_wheel_time),
        .i_crank_revs (i_crank_revs),
        .i_crank_time (i_crank_time),
        .i_full       (full),
        .o_push       (push),
        .o_flags      (fr_flags),
        .o_wheel_dr   (fr_wheel_dr),
        .o_wheel_dt   (fr_wheel_dt),
        .o_crank_dr   (fr_crank_dr),
        .o_crank_dt   (fr_crank_dt)
    );

    assign q_in = {fr_flags, fr_wheel_dr, fr_wheel_dt, fr_crank_dr, fr_crank_dt};

    wsc_fifo #(
        .DATA_W (JOB_W)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (q_in),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (q_out)
    );

    assign {bk_flags, bk_wheel_dr, bk_wheel_dt, bk_crank_dr, bk_crank_dt} = q_out;

    wsc_back #(
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_empty       (empty),
        .o_pop         (pop),
        .i_flags       (bk_flags),
        .i_wheel_dr    (bk_wheel_dr),
        .i_wheel_dt    (bk_wheel_dt),
        .i_crank_dr    (bk_crank_dr),
        .i_crank_dt    (bk_crank_dt),
        .i_cfg         (r_cfg),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_speed_kph   (o_speed_kph),
        .o_cadence_rpm (o_cadence_rpm)
    );

endmodule

// ===== sv/wsc_checker.sv =====
// port-level checker for the wheel speed and cadence calculator, with its bind
`timescale 1ns / 1ps

module wsc_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_cfg_valid,
    input logic                           o_cfg_ready,
    input logic [wsc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input logic [wsc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input logic                           o_valid,
    input logic                           i_ready,
    input logic [wsc_pkg::RES_W-1:0]      o_speed_kph,
    input logic [wsc_pkg::RES_W-1:0]      o_cadence_rpm
);

    logic [wsc_pkg::CAP_W-1:0] r_speed_cap;
    logic [wsc_pkg::CAP_W-1:0] r_cadence_cap;

    // shadow of the cap registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed_cap   <= wsc_pkg::SPEED_CAP_RST;
            r_cadence_cap <= wsc_pkg::CADENCE_CAP_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == wsc_pkg::CFG_SPEED_CAP) begin
                r_speed_cap <= i_cfg_data[wsc_pkg::CAP_W-1:0];
            end
            if (i_cfg_index == wsc_pkg::CFG_CADENCE_CAP) begin
                r_cadence_cap <= i_cfg_data[wsc_pkg::CAP_W-1:0];
            end
        end
    end

    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("output valid dropped before transaction");

    a_data_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> $stable(o_speed_kph) && $stable(o_cadence_rpm))
        else $error("output payload changed while stalled");

    a_speed_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_speed_kph <= r_speed_cap)
        else $error("speed above cap");

    a_cadence_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_cadence_rpm <= r_cadence_cap)
        else $error("cadence above cap");

    a_reset_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_valid)
        else $error("output valid right after reset");

endmodule

bind wheel_speed_cadence_calc wsc_checker u_wsc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_cfg_valid   (i_cfg_valid),
    .o_cfg_ready   (o_cfg_ready),
    .i_cfg_index   (i_cfg_index),
    .i_cfg_data    (i_cfg_data),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_speed_kph   (o_speed_kph),
    .o_cadence_rpm (o_cadence_rpm)
);
